// ----- design/traffic_rule_first_match_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the traffic rule classifier.
// Shared wrappers so that every checker reports in the same way.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_RULE_FIRST_MATCH_TOP_MACROS_SVH
`define TRAFFIC_RULE_FIRST_MATCH_TOP_MACROS_SVH

// Property checked out of reset only.
`define TFM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define TFM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/tfm_pkg.sv -----
// ----------------------------------------------------------------------------
// tfm_pkg
// Types, sizes and operation codes shared by the traffic rule classifier.
// ----------------------------------------------------------------------------
package tfm_pkg;

  localparam int RULES_PER_LIST = 32;
  localparam int LIST_COUNT     = 3;

  localparam int POS_W     = (RULES_PER_LIST > 1) ? $clog2(RULES_PER_LIST) : 1;
  localparam int FILL_W    = $clog2(RULES_PER_LIST + 1);
  localparam int LIST_W    = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int MEM_AW    = LIST_W + POS_W;
  localparam int MEM_DEPTH = LIST_COUNT * (2 ** POS_W);

  localparam int OP_W      = 2;
  localparam int LID_W     = 2;
  localparam int INDEX_W   = 5;
  localparam int OCT_W     = 3;
  localparam int MAX_OCTETS = 4;

  typedef enum logic [OP_W-1:0] {
    OP_CLASSIFY = 2'd0,
    OP_ADD      = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef struct packed {
    logic [7:0]       proto;
    logic             any_proto;
    logic [15:0]      port_lo;
    logic [15:0]      port_hi;
    logic [31:0]      bound_lo;
    logic [31:0]      bound_hi;
    logic [OCT_W-1:0] octets;
  } rule_t;

  typedef struct packed {
    logic [7:0]  proto;
    logic [31:0] addr;
    logic [15:0] port;
  } pkt_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    rule_t             data;
  } mem_wr_t;

  function automatic logic [INDEX_W-1:0] to_index(input logic [POS_W-1:0] pos);
    logic [POS_W+INDEX_W-1:0] ext;
    ext = {{INDEX_W{1'b0}}, pos};
    return ext[INDEX_W-1:0];
  endfunction

endpackage

// ----- design/tfm_rule_mem.sv -----
// ----------------------------------------------------------------------------
// tfm_rule_mem
// Rule storage for all lists, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tfm_rule_mem (
  input  logic                      clk,
  input  tfm_pkg::mem_wr_t          wr,
  input  logic [tfm_pkg::MEM_AW-1:0] rd_addr,
  output tfm_pkg::rule_t            rd_data
);
  import tfm_pkg::*;

  rule_t rule_mem_r [MEM_DEPTH];
  rule_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      rule_mem_r[wr.addr] <= wr.data;
    end
    rd_data_r <= rule_mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/tfm_match_unit.sv -----
// ----------------------------------------------------------------------------
// tfm_match_unit
// Compares one stored rule against the packet held for the current search.
// ----------------------------------------------------------------------------
module tfm_match_unit (
  input  tfm_pkg::rule_t rule,
  input  tfm_pkg::pkt_t  pkt,
  output logic           hit
);
  import tfm_pkg::*;

  logic [MAX_OCTETS-1:0] octet_ok;
  logic                  proto_ok;
  logic                  port_ok;

  always_comb begin
    logic [7:0] a_oct;
    logic [7:0] lo_oct;
    logic [7:0] hi_oct;
    for (int k = 0; k < MAX_OCTETS; k++) begin
      a_oct  = pkt.addr[31 - 8*k -: 8];
      lo_oct = rule.bound_lo[31 - 8*k -: 8];
      hi_oct = rule.bound_hi[31 - 8*k -: 8];
      octet_ok[k] = (OCT_W'(k) >= rule.octets) || ((a_oct >= lo_oct) && (a_oct <= hi_oct));
    end
    proto_ok = rule.any_proto || (rule.proto == pkt.proto);
    port_ok  = (pkt.port >= rule.port_lo) && (pkt.port <= rule.port_hi);
    hit      = proto_ok && port_ok && (&octet_ok);
  end

endmodule

// ----- design/traffic_rule_first_match_top.sv -----
// ----------------------------------------------------------------------------
// traffic_rule_first_match_top
// First-match classifier over ordered rule lists with add and clear commands.
//
//   Channel | Ports                      | Direction
//   --------+----------------------------+----------
//   input   | in_valid, in_stall, in_*   | into block
//   result  | out_valid, out_stall, out_*| out of block
//
// A taken word holds off the next one (in_stall stays high) until its result has moved
// into the output register. Add, clear and unknown commands go straight to the done state;
// a classify first reads rules, newest first, down to the first hit (at most 32), one rule
// per cycle through the single compare unit.
// Reset empties every list; the rule memory itself is not cleared.
// The result sits in an output register, so a new word is taken while it waits.
// ----------------------------------------------------------------------------
module traffic_rule_first_match_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tfm_pkg::OP_W-1:0]    in_operation,
  input  logic [tfm_pkg::LID_W-1:0]   in_list_id,
  input  logic [7:0]                  in_proto_value,
  input  logic                        in_any_protocol,
  input  logic [15:0]                 in_port_low,
  input  logic [15:0]                 in_port_high,
  input  logic [31:0]                 in_range_low,
  input  logic [31:0]                 in_range_high,
  input  logic [tfm_pkg::OCT_W-1:0]   in_octets_checked,
  input  logic [31:0]                 in_dest_address,
  input  logic [15:0]                 in_dest_port,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_matched,
  output logic [tfm_pkg::INDEX_W-1:0] out_matched_index,
  output logic                        out_status
);
  import tfm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [FILL_W-1:0]   fill_r   [LIST_COUNT];
  logic [FILL_W-1:0]   fill_nxt [LIST_COUNT];
  logic [LIST_W-1:0]   lst_r, lst_nxt;
  logic [POS_W-1:0]    ptr_r, ptr_nxt;
  pkt_t                pkt_r, pkt_nxt;
  logic                res_matched_r, res_matched_nxt;
  logic [INDEX_W-1:0]  res_index_r, res_index_nxt;
  logic                res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_matched_r, out_matched_nxt;
  logic [INDEX_W-1:0]  out_index_r, out_index_nxt;
  logic                out_status_r, out_status_nxt;

  logic                accept;
  logic                lst_ok;
  logic [LIST_W-1:0]   lst_idx;
  logic [FILL_W-1:0]   fill_cur;
  logic [OCT_W-1:0]    octets_sat;
  logic [MEM_AW-1:0]   rd_addr;
  mem_wr_t             mem_wr;
  rule_t               rd_rule;
  logic                hit;

  tfm_rule_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_rule)
  );

  tfm_match_unit u_match (
    .rule (rd_rule),
    .pkt  (pkt_r),
    .hit  (hit)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign lst_ok   = (32'(in_list_id) < LIST_COUNT);
  assign lst_idx  = LIST_W'(in_list_id);
  assign fill_cur = lst_ok ? fill_r[lst_idx] : '0;
  assign octets_sat = (in_octets_checked > OCT_W'(MAX_OCTETS)) ? OCT_W'(MAX_OCTETS)
                                                               : in_octets_checked;

  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    lst_nxt         = lst_r;
    ptr_nxt         = ptr_r;
    pkt_nxt         = pkt_r;
    res_matched_nxt = res_matched_r;
    res_index_nxt   = res_index_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_matched_nxt = out_matched_r;
    out_index_nxt   = out_index_r;
    out_status_nxt  = out_status_r;
    rd_addr         = {lst_r, ptr_r};
    mem_wr.en       = 1'b0;
    mem_wr.addr     = {lst_idx, POS_W'(fill_cur)};
    mem_wr.data.proto     = in_proto_value;
    mem_wr.data.any_proto = in_any_protocol;
    mem_wr.data.port_lo   = in_port_low;
    mem_wr.data.port_hi   = in_port_high;
    mem_wr.data.bound_lo  = in_range_low;
    mem_wr.data.bound_hi  = in_range_high;
    mem_wr.data.octets    = octets_sat;

    case (state_r)
      ST_IDLE: begin
        rd_addr = {lst_idx, POS_W'(fill_cur - 1'b1)};
        if (accept) begin
          res_matched_nxt = 1'b0;
          res_index_nxt   = '0;
          res_status_nxt  = 1'b0;
          state_nxt       = ST_DONE;
          case (in_operation)
            OP_CLASSIFY: begin
              if (fill_cur != '0) begin
                lst_nxt       = lst_idx;
                ptr_nxt       = POS_W'(fill_cur - 1'b1);
                pkt_nxt.proto = in_proto_value;
                pkt_nxt.addr  = in_dest_address;
                pkt_nxt.port  = in_dest_port;
                state_nxt     = ST_SCAN;
              end
            end
            OP_ADD: begin
              if (lst_ok && (32'(fill_cur) < RULES_PER_LIST)) begin
                mem_wr.en         = 1'b1;
                fill_nxt[lst_idx] = FILL_W'(fill_cur + 1'b1);
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            OP_CLEAR: begin
              if (lst_ok) begin
                fill_nxt[lst_idx] = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_matched_nxt = 1'b1;
          res_index_nxt   = to_index(ptr_r);
          state_nxt       = ST_DONE;
        end else if (ptr_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          ptr_nxt = ptr_r - 1'b1;
          rd_addr = {lst_r, ptr_r - 1'b1};
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_matched_nxt = res_matched_r;
          out_index_nxt   = res_index_r;
          out_status_nxt  = res_status_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LIST_COUNT; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lst_r         <= lst_nxt;
    ptr_r         <= ptr_nxt;
    pkt_r         <= pkt_nxt;
    res_matched_r <= res_matched_nxt;
    res_index_r   <= res_index_nxt;
    res_status_r  <= res_status_nxt;
    out_matched_r <= out_matched_nxt;
    out_index_r   <= out_index_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_matched       = out_matched_r;
  assign out_matched_index = out_index_r;
  assign out_status        = out_status_r;

endmodule

// ----- design/tfm_checker.sv -----
// ----------------------------------------------------------------------------
// tfm_checker
// Port-level checks on the classifier, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "traffic_rule_first_match_top_macros.svh"

module tfm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_matched,
  input logic [tfm_pkg::INDEX_W-1:0] out_matched_index,
  input logic                        out_status
);
  import tfm_pkg::*;

  `TFM_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_matched) && $stable(out_matched_index) && $stable(out_status), "Stalled result word changed.")
  `TFM_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall, "Block took a second word while busy.")
  `TFM_ASSERT(a_status_alone, clk, rst_n, out_valid && out_status |-> !out_matched && (out_matched_index == '0), "Refused add reported a match.")
  `TFM_ASSERT(a_index_no_match, clk, rst_n, out_valid && !out_matched |-> (out_matched_index == '0), "Index set without a match.")
  `TFM_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid && !in_stall, "Block not idle after reset.")

endmodule

bind traffic_rule_first_match_top tfm_checker u_tfm_checker (.*);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for the first-match traffic rule classifier
// Drives add, clear, classify and unknown words through the valid/stall input channel
// with random idle bursts on both sides. An in-bench copy of the rule lists
// works out the expected match flag, index and status for every accepted word,
// and a checker compares each result word with the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tfm_pkg::*;

  localparam logic [LID_W-1:0] LIST_BLOCK   = 2'd0;
  localparam logic [LID_W-1:0] LIST_ALLOW   = 2'd1;
  localparam logic [LID_W-1:0] LIST_HTTP    = 2'd2;
  localparam logic [LID_W-1:0] LIST_UNKNOWN = 2'd3;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PRINT_CAP    = 40;

  typedef struct packed {
    op_t              op;
    logic [LID_W-1:0] list;
    logic [7:0]       proto;
    logic             any_proto;
    logic [15:0]      port_lo;
    logic [15:0]      port_hi;
    logic [31:0]      bound_lo;
    logic [31:0]      bound_hi;
    logic [OCT_W-1:0] octets;
    logic [31:0]      dest_address;
    logic [15:0]      dest_port;
  } command_t;

  typedef struct packed {
    logic               matched;
    logic [INDEX_W-1:0] index;
    logic               status;
  } verdict_t;

  logic                clk;
  logic                rst_n             = 1'b0;
  logic                in_valid          = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation      = '0;
  logic [LID_W-1:0]    in_list_id        = '0;
  logic [7:0]          in_proto_value    = '0;
  logic                in_any_protocol   = 1'b0;
  logic [15:0]         in_port_low       = '0;
  logic [15:0]         in_port_high      = '0;
  logic [31:0]         in_range_low      = '0;
  logic [31:0]         in_range_high     = '0;
  logic [OCT_W-1:0]    in_octets_checked = '0;
  logic [31:0]         in_dest_address   = '0;
  logic [15:0]         in_dest_port      = '0;
  logic                out_valid;
  logic                out_stall         = 1'b0;
  logic                out_matched;
  logic [INDEX_W-1:0]  out_matched_index;
  logic                out_status;

  rule_t       rulebook [LIST_COUNT][RULES_PER_LIST];
  int unsigned list_size [LIST_COUNT];
  verdict_t    pending_verdicts [$];

  bit          idling_on     = 1'b1;
  int unsigned stall_left    = 0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned words_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned lookups       = 0;
  int unsigned lookup_hits   = 0;
  int unsigned refused_adds  = 0;

  traffic_rule_first_match_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_list_id        (in_list_id),
    .in_proto_value    (in_proto_value),
    .in_any_protocol   (in_any_protocol),
    .in_port_low       (in_port_low),
    .in_port_high      (in_port_high),
    .in_range_low      (in_range_low),
    .in_range_high     (in_range_high),
    .in_octets_checked (in_octets_checked),
    .in_dest_address   (in_dest_address),
    .in_dest_port      (in_dest_port),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_matched       (out_matched),
    .out_matched_index (out_matched_index),
    .out_status        (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit rule_covers(input rule_t r, input command_t c);
    bit         ok;
    logic [7:0] a_oct;
    logic [7:0] lo_oct;
    logic [7:0] hi_oct;
    ok = (r.any_proto || r.proto == c.proto) &&
         c.dest_port >= r.port_lo && c.dest_port <= r.port_hi;
    for (int k = 0; k < MAX_OCTETS; k++) begin
      if (k < r.octets) begin
        a_oct  = c.dest_address[31 - 8 * k -: 8];
        lo_oct = r.bound_lo[31 - 8 * k -: 8];
        hi_oct = r.bound_hi[31 - 8 * k -: 8];
        if (a_oct < lo_oct || a_oct > hi_oct) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic verdict_t predict_verdict(input command_t c);
    verdict_t v;
    rule_t    r;
    v.matched = 1'b0;
    v.index   = '0;
    v.status  = STATUS_DONE;
    case (c.op)
      OP_CLASSIFY: begin
        if (c.list < LIST_COUNT) begin
          for (int p = int'(list_size[c.list]) - 1; p >= 0 && !v.matched; p--) begin
            if (rule_covers(rulebook[c.list][p], c)) begin
              v.matched = 1'b1;
              v.index   = p[INDEX_W-1:0];
            end
          end
        end
      end
      OP_ADD: begin
        if (c.list >= LIST_COUNT || list_size[c.list] >= RULES_PER_LIST) begin
          v.status = STATUS_FULL;
        end else begin
          r.proto     = c.proto;
          r.any_proto = c.any_proto;
          r.port_lo   = c.port_lo;
          r.port_hi   = c.port_hi;
          r.bound_lo  = c.bound_lo;
          r.bound_hi  = c.bound_hi;
          r.octets    = (c.octets > MAX_OCTETS) ? OCT_W'(MAX_OCTETS) : c.octets;
          rulebook[c.list][list_size[c.list]] = r;
          list_size[c.list]++;
        end
      end
      OP_CLEAR: begin
        if (c.list < LIST_COUNT) list_size[c.list] = 0;
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  function automatic command_t random_word();
    command_t c;
    c.op           = op_t'($urandom_range(0, 3));
    c.list         = LID_W'($urandom_range(0, 3));
    c.proto        = 8'($urandom);
    c.any_proto    = 1'($urandom);
    c.port_lo      = 16'($urandom);
    c.port_hi      = 16'($urandom);
    c.bound_lo     = $urandom;
    c.bound_hi     = $urandom;
    c.octets       = OCT_W'($urandom);
    c.dest_address = $urandom;
    c.dest_port    = 16'($urandom);
    return c;
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 3))
      0: return PROTO_TCP;
      1: return PROTO_UDP;
      2: return PROTO_ICMP;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 9))
      0: return 16'd80;
      1: return 16'd443;
      2: return 16'd53;
      3: return 16'd22;
      4: return 16'd8080;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_between(input logic [7:0] lo, input logic [7:0] hi);
    if (lo <= hi) return 8'($urandom_range(hi, lo));
    return 8'($urandom);
  endfunction

  function automatic command_t rule_word(input logic [LID_W-1:0] lst, input logic [7:0] proto,
                                         input logic any, input logic [15:0] plo,
                                         input logic [15:0] phi, input logic [31:0] blo,
                                         input logic [31:0] bhi, input logic [OCT_W-1:0] n);
    command_t c;
    c           = random_word();
    c.op        = OP_ADD;
    c.list      = lst;
    c.proto     = proto;
    c.any_proto = any;
    c.port_lo   = plo;
    c.port_hi   = phi;
    c.bound_lo  = blo;
    c.bound_hi  = bhi;
    c.octets    = n;
    return c;
  endfunction

  function automatic command_t packet_word(input logic [LID_W-1:0] lst, input logic [7:0] proto,
                                           input logic [31:0] addr, input logic [15:0] port);
    command_t c;
    c              = random_word();
    c.op           = OP_CLASSIFY;
    c.list         = lst;
    c.proto        = proto;
    c.dest_address = addr;
    c.dest_port    = port;
    return c;
  endfunction

  function automatic command_t clear_word(input logic [LID_W-1:0] lst);
    command_t c;
    c      = random_word();
    c.op   = OP_CLEAR;
    c.list = lst;
    return c;
  endfunction

  function automatic command_t make_rule(input logic [LID_W-1:0] lst);
    command_t    c;
    int unsigned top;
    logic [7:0]  lo_oct;
    logic [7:0]  hi_oct;
    c           = random_word();
    c.op        = OP_ADD;
    c.list      = lst;
    c.proto     = pick_proto();
    c.any_proto = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 9))
      0: begin
        c.port_lo = 16'h0000;
        c.port_hi = 16'hFFFF;
      end
      1: begin
        c.port_lo = 16'($urandom_range(1, 65535));
        c.port_hi = 16'($urandom_range(0, c.port_lo - 1));
      end
      2, 3: begin
        c.port_lo = pick_port();
        c.port_hi = c.port_lo;
      end
      default: begin
        c.port_lo = pick_port();
        top       = c.port_lo + $urandom_range(0, 4000);
        c.port_hi = (top > 65535) ? 16'hFFFF : top[15:0];
      end
    endcase
    for (int k = 0; k < MAX_OCTETS; k++) begin
      case ($urandom_range(0, 5))
        0: begin
          lo_oct = 8'h00;
          hi_oct = 8'hFF;
        end
        1: begin
          lo_oct = 8'($urandom_range(1, 255));
          hi_oct = 8'($urandom_range(0, lo_oct - 1));
        end
        2: begin
          lo_oct = 8'($urandom);
          hi_oct = lo_oct;
        end
        default: begin
          lo_oct = 8'($urandom);
          top    = lo_oct + $urandom_range(0, 40);
          hi_oct = (top > 255) ? 8'hFF : top[7:0];
        end
      endcase
      c.bound_lo = {c.bound_lo[23:0], lo_oct};
      c.bound_hi = {c.bound_hi[23:0], hi_oct};
    end
    c.octets = OCT_W'($urandom_range(0, 7));
    return c;
  endfunction

  // Most packets are aimed at a stored rule so that the search reaches deep
  // into the list; some get one bit flipped to land just outside it.
  function automatic command_t make_packet(input logic [LID_W-1:0] lst);
    command_t c;
    rule_t    r;
    c    = random_word();
    c.op = OP_CLASSIFY;
    c.list = lst;
    if (lst < LIST_COUNT && list_size[lst] != 0 && $urandom_range(0, 3) != 0) begin
      r       = rulebook[lst][$urandom_range(0, list_size[lst] - 1)];
      c.proto = r.any_proto ? pick_proto() : r.proto;
      c.dest_port = (r.port_lo <= r.port_hi) ? 16'($urandom_range(r.port_hi, r.port_lo))
                                             : 16'($urandom);
      for (int k = 0; k < MAX_OCTETS; k++) begin
        c.dest_address = {c.dest_address[23:0],
                          pick_between(r.bound_lo[31 - 8 * k -: 8],
                                       r.bound_hi[31 - 8 * k -: 8])};
      end
      if ($urandom_range(0, 6) == 0) begin
        case ($urandom_range(0, 2))
          0: c.proto = c.proto ^ (8'd1 << $urandom_range(0, 7));
          1: c.dest_port = c.dest_port ^ (16'd1 << $urandom_range(0, 15));
          default: c.dest_address = c.dest_address ^ (32'd1 << $urandom_range(0, 31));
        endcase
      end
    end else begin
      c.proto     = pick_proto();
      c.dest_port = pick_port();
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic send_word(input command_t c);
    verdict_t v;
    in_valid          <= 1'b1;
    in_operation      <= c.op;
    in_list_id        <= c.list;
    in_proto_value    <= c.proto;
    in_any_protocol   <= c.any_proto;
    in_port_low       <= c.port_lo;
    in_port_high      <= c.port_hi;
    in_range_low      <= c.bound_lo;
    in_range_high     <= c.bound_hi;
    in_octets_checked <= c.octets;
    in_dest_address   <= c.dest_address;
    in_dest_port      <= c.dest_port;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    v = predict_verdict(c);
    pending_verdicts.push_back(v);
    words_sent++;
    if (c.op == OP_CLASSIFY) lookups++;
    if (v.matched) lookup_hits++;
    if (v.status == STATUS_FULL) refused_adds++;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) stall_left = stall_left - 1;
    else if (rst_n && idling_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 16);
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin : check_result
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result word arrived with nothing expected");
      end else begin
        want = pending_verdicts.pop_front();
        results_seen++;
        if (out_matched !== want.matched)
          report_mismatch($sformatf("matched %b, expected %b", out_matched, want.matched));
        if (out_matched_index !== want.index)
          report_mismatch($sformatf("matched_index %0d, expected %0d",
                                    out_matched_index, want.index));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %b, expected %b", out_status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_verdicts.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic test_directed_cases();
    command_t c;
    send_word(packet_word(LIST_BLOCK, PROTO_TCP, 32'h0A000001, 16'd80));
    send_word(rule_word(LIST_BLOCK, PROTO_TCP, 1'b0, 16'd80, 16'd80,
                        32'h0A000000, 32'h0AFFFFFF, 3'd1));
    send_word(packet_word(LIST_BLOCK, PROTO_TCP, 32'h0A010203, 16'd80));
    send_word(packet_word(LIST_BLOCK, PROTO_TCP, 32'h0B010203, 16'd80));
    send_word(rule_word(LIST_BLOCK, 8'h00, 1'b1, 16'h0000, 16'hFFFF,
                        32'hFFFFFFFF, 32'h00000000, 3'd0));
    send_word(packet_word(LIST_BLOCK, PROTO_UDP, 32'h0A010203, 16'd80));
    send_word(packet_word(LIST_BLOCK, PROTO_TCP, 32'hFFFFFFFF, 16'hFFFF));
    send_word(rule_word(LIST_ALLOW, PROTO_UDP, 1'b0, 16'd53, 16'd53,
                        32'hC0A80100, 32'hC0A801FF, 3'd7));
    send_word(packet_word(LIST_ALLOW, PROTO_UDP, 32'hC0A8014D, 16'd53));
    send_word(packet_word(LIST_ALLOW, PROTO_UDP, 32'hC0A8024D, 16'd53));
    send_word(packet_word(LIST_ALLOW, PROTO_TCP, 32'hC0A8014D, 16'd53));
    send_word(packet_word(LIST_ALLOW, PROTO_UDP, 32'hC0A8014D, 16'd54));
    send_word(rule_word(LIST_HTTP, 8'hFF, 1'b1, 16'd1000, 16'd999,
                        32'h00000000, 32'hFFFFFFFF, 3'd4));
    send_word(packet_word(LIST_HTTP, 8'hFF, 32'h12345678, 16'd999));
    send_word(packet_word(LIST_HTTP, 8'hFF, 32'h12345678, 16'd1000));
    send_word(rule_word(LIST_HTTP, 8'hFF, 1'b0, 16'hFFFF, 16'hFFFF,
                        32'hFFFFFFFF, 32'hFFFFFFFF, 3'd4));
    send_word(packet_word(LIST_HTTP, 8'hFF, 32'hFFFFFFFF, 16'hFFFF));
    send_word(packet_word(LIST_HTTP, 8'h00, 32'h00000000, 16'h0000));
    c    = random_word();
    c.op = OP_NONE;
    send_word(c);
    send_word(make_rule(LIST_UNKNOWN));
    send_word(packet_word(LIST_UNKNOWN, 8'h00, 32'h00000000, 16'h0000));
    send_word(clear_word(LIST_UNKNOWN));
    send_word(clear_word(LIST_BLOCK));
    send_word(packet_word(LIST_BLOCK, PROTO_UDP, 32'h0A010203, 16'd80));
    send_word(rule_word(LIST_BLOCK, 8'h00, 1'b0, 16'h0000, 16'h0000,
                        32'h00000000, 32'h00000000, 3'd4));
    send_word(packet_word(LIST_BLOCK, 8'h00, 32'h00000000, 16'h0000));
  endtask

  task automatic test_full_list();
    send_word(clear_word(LIST_ALLOW));
    send_word(rule_word(LIST_ALLOW, 8'h00, 1'b1, 16'h0000, 16'hFFFF,
                        32'h00000000, 32'h00000000, 3'd0));
    repeat (RULES_PER_LIST - 1) send_word(make_rule(LIST_ALLOW));
    send_word(make_rule(LIST_ALLOW));
    repeat (8) send_word(make_packet(LIST_ALLOW));
  endtask

  task automatic test_mixed_traffic(input int unsigned words, input bit allow_idle);
    int unsigned      pick;
    logic [LID_W-1:0] lst;
    for (int unsigned n = 0; n < words; n++) begin
      if (n % 64 == 0) idling_on = allow_idle && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      lst  = LID_W'($urandom_range(0, LIST_COUNT - 1));
      if (pick < 55) send_word(make_packet(lst));
      else if (pick < 82) send_word(make_rule(lst));
      else if (pick < 86) send_word(clear_word(lst));
      else send_word(random_word());
    end
  endtask

  task automatic test_steady_stream();
    idling_on = 1'b0;
    test_mixed_traffic(100, 1'b0);
  endtask

  initial begin
    for (int l = 0; l < LIST_COUNT; l++) list_size[l] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_full_list();
    test_mixed_traffic(780, 1'b1);
    test_steady_stream();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words and %0d result words: %0d lookups with %0d hits",
             words_sent, results_seen, lookups, lookup_hits);
    $display("refused adds (full or unknown list): %0d, mismatches: %0d",
             refused_adds, mismatches);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
